// ----- rtl/core/lts_pkg.sv -----
// Package: token types, scanner mode codes, character codes and helper functions.
package lts_pkg;

   localparam logic [31:0] MAX_TOKEN_LENGTH = 32'd65535;
   localparam logic [31:0] LEN_CAP = (MAX_TOKEN_LENGTH < 32'h0000_FFFF) ?
                                     MAX_TOKEN_LENGTH : 32'h0000_FFFF;
   localparam int unsigned MAX_RESULTS = 3;

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef enum logic [3:0] {
      M_IDLE    = 4'd0,
      M_SLASH   = 4'd1,
      M_COMMENT = 4'd2,
      M_BANG    = 4'd3,
      M_EQUAL   = 4'd4,
      M_LESS    = 4'd5,
      M_GREATER = 4'd6,
      M_INT     = 4'd7,
      M_DOT     = 4'd8,
      M_FRAC    = 4'd9,
      M_STRING  = 4'd10
   } scan_mode_type;

   typedef enum logic [4:0] {
      K_LPAREN     = 5'd0,
      K_RPAREN     = 5'd1,
      K_LBRACE     = 5'd2,
      K_RBRACE     = 5'd3,
      K_SEMI       = 5'd4,
      K_COMMA      = 5'd5,
      K_DOT        = 5'd6,
      K_MINUS      = 5'd7,
      K_PLUS       = 5'd8,
      K_SLASH      = 5'd9,
      K_STAR       = 5'd10,
      K_BANG       = 5'd11,
      K_BANG_EQ    = 5'd12,
      K_EQ         = 5'd13,
      K_EQ_EQ      = 5'd14,
      K_LESS       = 5'd15,
      K_LESS_EQ    = 5'd16,
      K_GREATER    = 5'd17,
      K_GREATER_EQ = 5'd18,
      K_STRING     = 5'd19,
      K_NUMBER     = 5'd20,
      K_UNTERM     = 5'd21,
      K_UNEXP      = 5'd22,
      K_EOF        = 5'd23
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [31:0]    start;
      logic [15:0]    length;
      logic [31:0]    line;
   } token_type;

   // Up to three tokens produced by one source byte, in emission order
   typedef struct packed {
      logic [1:0]                      count;
      token_type [MAX_RESULTS-1:0]     slot;
   } bundle_type;

   function automatic logic [15:0] sat_len(input logic [31:0] d);
      return (d > LEN_CAP) ? LEN_CAP[15:0] : d[15:0];
   endfunction

   function automatic token_type mk_token(input token_kind_type kind,
                                          input logic [31:0] start,
                                          input logic [31:0] len,
                                          input logic [31:0] line);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = sat_len(len);
      t.line   = line;
      return t;
   endfunction

   // Operator kind for a pending ! = < > with or without a trailing '='
   function automatic token_kind_type op_kind(input scan_mode_type m, input logic pair);
      token_kind_type k;
      case (m)
         M_BANG:    k = pair ? K_BANG_EQ    : K_BANG;
         M_EQUAL:   k = pair ? K_EQ_EQ      : K_EQ;
         M_LESS:    k = pair ? K_LESS_EQ    : K_LESS;
         M_GREATER: k = pair ? K_GREATER_EQ : K_GREATER;
         default:   k = K_UNEXP;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/core/lts_if.sv -----
// Interfaces: source byte channel and token channel.
interface lts_req_if;
   import lts_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface lts_rsp_if;
   import lts_pkg::*;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] token_start;
   logic [15:0] token_length;
   logic [31:0] token_line;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output token_line, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input token_line, input last_of_run,
                   output ready);
endinterface

// ----- rtl/core/lts_scan.sv -----
// Scanner state and per-byte token decode.
module lts_scan
   import lts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] ch,
   output bundle_type bundle
);

   scan_mode_type mode_ff, mode_in;
   logic [31:0]   start_ff, start_in;
   logic [31:0]   pos_ff, pos_in;
   logic [31:0]   line_ff, line_in;

   token_type brk0, brk1, p0, tail;
   logic      brk0_v, brk1_v, p0_v, p1_v, t_v;
   logic      fall, nl, is_digit;
   logic [31:0] pm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= 32'd1;
      end else if (step) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
      end
   end

   always_comb begin
      pm1      = pos_ff - 32'd1;
      is_digit = (ch >= CH_0) && (ch <= CH_9);

      // Tokens owed by the pending mode when the next byte does not extend it
      brk0_v = 1'b0;
      brk1_v = 1'b0;
      brk0   = mk_token(K_SLASH, start_ff, 32'd1, line_ff);
      brk1   = mk_token(K_DOT, pm1, 32'd1, line_ff);
      unique case (mode_ff)
         M_SLASH: begin
            brk0_v = 1'b1;
         end
         M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
            brk0_v = 1'b1;
            brk0   = mk_token(op_kind(mode_ff, 1'b0), start_ff, 32'd1, line_ff);
         end
         M_INT, M_FRAC: begin
            brk0_v = 1'b1;
            brk0   = mk_token(K_NUMBER, start_ff, pos_ff - start_ff, line_ff);
         end
         M_DOT: begin
            brk0_v = 1'b1;
            brk1_v = 1'b1;
            brk0   = mk_token(K_NUMBER, start_ff, pm1 - start_ff, line_ff);
         end
         M_STRING: begin
            brk0_v = 1'b1;
            brk0   = mk_token(K_UNTERM, start_ff, pos_ff - start_ff, line_ff);
         end
         default: begin
         end
      endcase

      mode_in  = mode_ff;
      start_in = start_ff;
      pos_in   = pos_ff + 32'd1;
      line_in  = line_ff;
      p0       = brk0;
      p0_v     = 1'b0;
      p1_v     = 1'b0;
      t_v      = 1'b0;
      tail     = mk_token(K_EOF, pos_ff, 32'd0, line_ff);
      fall     = 1'b0;
      nl       = 1'b0;

      if (ch == CH_NUL) begin
         // End of source: flush, then eof, then back to reset values
         p0_v     = brk0_v;
         p1_v     = brk1_v;
         t_v      = 1'b1;
         mode_in  = M_IDLE;
         start_in = '0;
         pos_in   = '0;
         line_in  = 32'd1;
      end else begin
         unique case (mode_ff)
            M_SLASH: begin
               if (ch == CH_SLASH) begin
                  mode_in = M_COMMENT;
               end else begin
                  p0_v = 1'b1;
                  fall = 1'b1;
               end
            end
            M_COMMENT: begin
               if (ch == CH_LF) begin
                  nl      = 1'b1;
                  mode_in = M_IDLE;
               end
            end
            M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
               p0_v = 1'b1;
               if (ch == CH_EQ) begin
                  p0      = mk_token(op_kind(mode_ff, 1'b1), start_ff, 32'd2, line_ff);
                  mode_in = M_IDLE;
               end else begin
                  fall = 1'b1;
               end
            end
            M_INT: begin
               if (ch == CH_DOT) begin
                  mode_in = M_DOT;
               end else if (!is_digit) begin
                  p0_v = 1'b1;
                  fall = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit) begin
                  mode_in = M_FRAC;
               end else begin
                  p0_v = 1'b1;
                  p1_v = 1'b1;
                  fall = 1'b1;
               end
            end
            M_FRAC: begin
               if (!is_digit) begin
                  p0_v = 1'b1;
                  fall = 1'b1;
               end
            end
            M_STRING: begin
               if (ch == CH_QUOTE) begin
                  p0_v    = 1'b1;
                  p0      = mk_token(K_STRING, start_ff, pos_ff - start_ff + 32'd1, line_ff);
                  mode_in = M_IDLE;
               end else if (ch == CH_LF) begin
                  nl = 1'b1;
               end
            end
            default: begin
               fall = 1'b1;
            end
         endcase

         // Byte starts afresh
         if (fall) begin
            mode_in = M_IDLE;
            case (ch) inside
               CH_SP, CH_CR, CH_TAB: begin
               end
               CH_LF: nl = 1'b1;
               CH_LPAREN: begin t_v = 1'b1; tail = mk_token(K_LPAREN, pos_ff, 32'd1, line_ff); end
               CH_RPAREN: begin t_v = 1'b1; tail = mk_token(K_RPAREN, pos_ff, 32'd1, line_ff); end
               CH_LBRACE: begin t_v = 1'b1; tail = mk_token(K_LBRACE, pos_ff, 32'd1, line_ff); end
               CH_RBRACE: begin t_v = 1'b1; tail = mk_token(K_RBRACE, pos_ff, 32'd1, line_ff); end
               CH_SEMI:   begin t_v = 1'b1; tail = mk_token(K_SEMI, pos_ff, 32'd1, line_ff); end
               CH_COMMA:  begin t_v = 1'b1; tail = mk_token(K_COMMA, pos_ff, 32'd1, line_ff); end
               CH_DOT:    begin t_v = 1'b1; tail = mk_token(K_DOT, pos_ff, 32'd1, line_ff); end
               CH_MINUS:  begin t_v = 1'b1; tail = mk_token(K_MINUS, pos_ff, 32'd1, line_ff); end
               CH_PLUS:   begin t_v = 1'b1; tail = mk_token(K_PLUS, pos_ff, 32'd1, line_ff); end
               CH_STAR:   begin t_v = 1'b1; tail = mk_token(K_STAR, pos_ff, 32'd1, line_ff); end
               CH_SLASH:  begin mode_in = M_SLASH;   start_in = pos_ff; end
               CH_BANG:   begin mode_in = M_BANG;    start_in = pos_ff; end
               CH_EQ:     begin mode_in = M_EQUAL;   start_in = pos_ff; end
               CH_LT:     begin mode_in = M_LESS;    start_in = pos_ff; end
               CH_GT:     begin mode_in = M_GREATER; start_in = pos_ff; end
               CH_QUOTE:  begin mode_in = M_STRING;  start_in = pos_ff; end
               [CH_0:CH_9]: begin mode_in = M_INT;   start_in = pos_ff; end
               default: begin
                  t_v  = 1'b1;
                  tail = mk_token(K_UNEXP, pos_ff, 32'd1, line_ff);
               end
            endcase
         end

         if (nl && (line_ff != 32'hFFFF_FFFF)) begin
            line_in = line_ff + 32'd1;
         end
      end

      // Pack in order; the second pending token only exists with the first
      bundle.count   = {1'b0, p0_v} + {1'b0, p1_v} + {1'b0, t_v};
      bundle.slot[0] = p0_v ? p0 : tail;
      bundle.slot[1] = p1_v ? brk1 : tail;
      bundle.slot[2] = tail;
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 32'd0)
      else $error("line count reached zero");

   a_eof_resets: assert property (@(posedge clock) disable iff (reset)
      step && (ch == CH_NUL) |=> (pos_ff == 32'd0) && (line_ff == 32'd1) &&
                                 (mode_ff == M_IDLE) && (start_ff == 32'd0))
      else $error("scanner state not restored after end of source");

endmodule

// ----- rtl/core/lts_out.sv -----
// Result register: holds one byte's tokens and hands them out one per transfer.
module lts_out
   import lts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  bundle_type   bundle,
   output logic         free,
   lts_rsp_if.source    rsp_bus
);

   logic [1:0]                  cnt_ff, cnt_in;
   logic [1:0]                  idx_ff, idx_in;
   token_type [MAX_RESULTS-1:0] slot_ff, slot_in;
   logic                        last;
   token_type                   head;

   assign last = (idx_ff == (cnt_ff - 2'd1));
   assign free = (cnt_ff == 2'd0) || (rsp_bus.ready && last);
   assign head = slot_ff[idx_ff];

   assign rsp_bus.valid        = (cnt_ff != 2'd0);
   assign rsp_bus.token_kind   = head.kind;
   assign rsp_bus.token_start  = head.start;
   assign rsp_bus.token_length = head.length;
   assign rsp_bus.token_line   = head.line;
   assign rsp_bus.last_of_run  = last;

   always_comb begin
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      slot_in = slot_ff;
      if (load) begin
         cnt_in  = bundle.count;
         idx_in  = 2'd0;
         slot_in = bundle.slot;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (last) begin
            cnt_in = 2'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
      slot_ff <= slot_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (idx_ff < cnt_ff))
      else $error("result index beyond stored count");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_of_run |=> rsp_bus.valid)
      else $error("token run cut short");

endmodule

// ----- rtl/core/lox_token_scanner.sv -----
// Top level: input register, scanner and result register of the token scanner.
// Data path: a transferred byte is held in the input register and scanned once the result
//   register is free; its tokens are loaded into the result register and offered from there.
// Throughput: one byte per cycle while each byte yields at most one token and the output
//   is ready; a byte with more tokens holds the result register and input until taken.
// Reset: synchronous; empties the input and result registers, mode idle, position 0, line 1.
module lox_token_scanner
   import lts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lts_req_if.sink   req_bus,
   lts_rsp_if.source rsp_bus
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff, in_ch_in;
   logic       free, load;
   bundle_type bundle;

   assign load          = in_valid_ff && free;
   assign req_bus.ready = !in_valid_ff || free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_ch_in    = req_bus.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ch_ff <= in_ch_in;
   end

   lts_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (load),
      .ch     (in_ch_ff),
      .bundle (bundle)
   );

   lts_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .bundle  (bundle),
      .free    (free),
      .rsp_bus (rsp_bus)
   );

endmodule
